// ===== sv/damped_spring_wobble_step_macros.svh =====
// assertion helpers for the wobble step block
`ifndef DAMPED_SPRING_WOBBLE_STEP_MACROS_SVH
`define DAMPED_SPRING_WOBBLE_STEP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define DSW_ASSERT_SAME(label, lhs, rhs) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (lhs) |-> (rhs)) \
        else $error("wobble step check failed");
// next-cycle implication, checked out of reset
`define DSW_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (lhs) |=> (rhs)) \
        else $error("wobble step check failed");
`else
`define DSW_ASSERT_SAME(label, lhs, rhs)
`define DSW_ASSERT_NEXT(label, lhs, rhs)
`endif

`endif

// ===== sv/dsw_pkg.sv =====
package dsw_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DIV_W         = 64;
    localparam int DSR_W         = 32;

    // configuration register indexes
    localparam logic [1:0] CFG_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_DRIVE   = 2'd1;
    localparam logic [1:0] CFG_SPRING  = 2'd2;
    localparam logic [1:0] CFG_DAMPING = 2'd3;

    // divide jobs
    localparam logic [2:0] D_VX  = 3'd0;
    localparam logic [2:0] D_VY  = 3'd1;
    localparam logic [2:0] D_AX  = 3'd2;
    localparam logic [2:0] D_AY  = 3'd3;
    localparam logic [2:0] D_PRJ = 3'd4;

    // multiply jobs
    localparam logic [3:0] M_DXX  = 4'd0;
    localparam logic [3:0] M_DYY  = 4'd1;
    localparam logic [3:0] M_AXDY = 4'd2;
    localparam logic [3:0] M_AYDX = 4'd3;
    localparam logic [3:0] M_DRV  = 4'd4;
    localparam logic [3:0] M_SPR  = 4'd5;
    localparam logic [3:0] M_DMP  = 4'd6;
    localparam logic [3:0] M_FDT  = 4'd7;
    localparam logic [3:0] M_RDT  = 4'd8;

    localparam logic signed [63:0] LIM_HI = 64'sd2147483647;
    localparam logic signed [63:0] LIM_LO = -64'sd2147483648;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } dsw_div_stat_t;

    // clamp a signed wide value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > LIM_HI) begin
            r = 32'sh7fffffff;
        end else if (x < LIM_LO) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // clamp a sign and magnitude pair to 32 bits
    function automatic logic signed [31:0] sat_mag(input logic neg, input logic [63:0] q);
        logic signed [31:0] r;
        if (!neg) begin
            r = (q > 64'd2147483647) ? 32'sh7fffffff : q[31:0];
        end else begin
            r = (q > 64'd2147483648) ? 32'sh80000000 : (~q[31:0] + 32'd1);
        end
        return r;
    endfunction

endpackage

// ===== sv/dsw_div.sv =====
module dsw_div
    import dsw_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DIV_W-1:0]   dividend,
    input  logic [DSR_W-1:0]   divisor,
    output dsw_div_stat_t      stat,
    output logic [DIV_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_W-1:0]   dvd_reg, dvd_next;
    logic [DSR_W:0]     rem_reg, rem_next;
    logic [DSR_W-1:0]   dsr_reg, dsr_next;
    logic [DSR_W:0]     rem_sh;
    logic               fits;

    // one quotient bit a cycle, restoring
    always_comb begin
        rem_sh    = {rem_reg[DSR_W-1:0], dvd_reg[DIV_W-1]};
        fits      = rem_sh >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
            dvd_next = {dvd_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dvd_reg;

endmodule

// ===== sv/damped_spring_wobble_step.sv =====
// channel   | direction | signals
// ----------+-----------+-----------------------------------------------------
// s_        | in        | s_valid/s_ready, pivot, tip, time step, lever flag
// m_        | out       | m_valid/m_ready, angle, angle rate
// cfg_      | in        | cfg_we, cfg_index, cfg_data (write only)
//
// one request at a time; a step with positive time runs four or five divides (start,
// 64 steps, done) on the shared radix-2 divider, plus, for a long lever, halving steps,
// 32 square-root steps and the multiplies.
// a step with non-positive time returns the held angle and rate in the next cycle.
// reset (synchronous, active low) clears the history, angle and rate and
// loads the gain defaults; s_ready stays low until the result is taken.
`include "damped_spring_wobble_step_macros.svh"

module damped_spring_wobble_step
    import dsw_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pivot_x,
    input  logic signed [31:0] s_pivot_y,
    input  logic signed [31:0] s_tip_x,
    input  logic signed [31:0] s_tip_y,
    input  logic signed [31:0] s_time_step,
    input  logic               s_lever_long,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_angle,
    output logic signed [31:0] m_angle_rate,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DSTART = 3'd1;
    localparam logic [2:0] S_DWAIT  = 3'd2;
    localparam logic [2:0] S_HALF   = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_SQRT   = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    localparam longint GRAV_Q = ((longint'(1) <<< FRAC_BITS) + 50) / 100;
    localparam logic signed [63:0] GRAV = 64'(GRAV_Q);
    localparam logic signed [63:0] RND = (64'sd1 <<< FRAC_BITS) - 64'sd1;
    localparam logic signed [32:0] BIG_P = 33'sd1073741824;
    localparam logic signed [32:0] BIG_N = -33'sd1073741824;
    localparam logic [63:0] SQ_TOP = 64'd1 << 62;

    // truncating divide by the fraction scale
    function automatic logic signed [63:0] tz(input logic signed [63:0] x);
        return (x + (x[63] ? RND : 64'sd0)) >>> FRAC_BITS;
    endfunction

    function automatic logic big(input logic signed [32:0] x);
        return (x >= BIG_P) || (x <= BIG_N);
    endfunction

    function automatic logic signed [32:0] half(input logic signed [32:0] x);
        return (x + $signed({32'd0, x[32]})) >>> 1;
    endfunction

    logic [2:0]          state_reg;
    logic [2:0]          dop_reg;
    logic [3:0]          mop_reg;
    logic                mph_reg;

    logic                en_reg;
    logic [30:0]         drive_reg, spring_reg, damp_reg;

    logic signed [31:0]  px_reg, py_reg, dt_reg;
    logic                long_reg;
    logic signed [32:0]  dx_reg, dy_reg;
    logic signed [31:0]  vx_reg, vy_reg, ax_reg, ay_reg, proj_reg, f_reg;
    logic signed [31:0]  ppx_reg, ppy_reg, pvx_reg, pvy_reg;
    logic signed [31:0]  angle_reg, rate_reg;
    logic signed [63:0]  acc_reg, prod_reg;
    logic [63:0]         sq_n_reg, sq_res_reg, sq_bit_reg;
    logic [31:0]         len_reg;
    logic                div_neg_reg;

    logic                accept;
    logic signed [63:0]  num;
    logic [63:0]         num_mag;
    logic [31:0]         dsr;
    logic                div_start;
    dsw_div_stat_t       div_stat;
    logic [63:0]         div_quo;
    logic signed [31:0]  div_val;
    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  mul_p;
    logic signed [63:0]  prod_tz;
    logic [63:0]         sq_try, sq_res_next;
    logic                sq_fit;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = (state_reg == S_OUT);
    assign m_angle      = angle_reg;
    assign m_angle_rate = rate_reg;
    assign div_start = (state_reg == S_DSTART);

    // numerator and divisor of the current divide job
    always_comb begin
        case (dop_reg)
            D_VX:    num = (64'(px_reg) - 64'(ppx_reg)) <<< FRAC_BITS;
            D_VY:    num = (64'(py_reg) - 64'(ppy_reg)) <<< FRAC_BITS;
            D_AX:    num = (64'(vx_reg) - 64'(pvx_reg)) <<< FRAC_BITS;
            D_AY:    num = (64'(vy_reg) - 64'(pvy_reg) + GRAV) <<< FRAC_BITS;
            default: num = acc_reg;
        endcase
        num_mag = num[63] ? 64'(-num) : 64'(num);
        dsr     = (dop_reg == D_PRJ) ? len_reg : 32'(dt_reg);
    end

    dsw_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_mag),
        .divisor  (dsr),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign div_val = sat_mag(div_neg_reg, div_quo);

    // shared multiplier operands
    always_comb begin
        case (mop_reg)
            M_DXX:   begin mul_a = dx_reg;               mul_b = dx_reg;          end
            M_DYY:   begin mul_a = dy_reg;               mul_b = dy_reg;          end
            M_AXDY:  begin mul_a = 33'(ax_reg);          mul_b = -dy_reg;         end
            M_AYDX:  begin mul_a = 33'(ay_reg);          mul_b = dx_reg;          end
            M_DRV:   begin mul_a = $signed({2'b0, drive_reg});  mul_b = 33'(proj_reg); end
            M_SPR:   begin mul_a = $signed({2'b0, spring_reg}); mul_b = 33'(angle_reg); end
            M_DMP:   begin mul_a = $signed({2'b0, damp_reg});   mul_b = 33'(rate_reg); end
            M_FDT:   begin mul_a = 33'(f_reg);           mul_b = 33'(dt_reg);     end
            default: begin mul_a = 33'(rate_reg);        mul_b = 33'(dt_reg);     end
        endcase
        mul_p   = mul_a * mul_b;
        prod_tz = tz(prod_reg);
    end

    // square root step
    always_comb begin
        sq_try      = sq_res_reg + sq_bit_reg;
        sq_fit      = sq_n_reg >= sq_try;
        sq_res_next = sq_fit ? ((sq_res_reg >> 1) + sq_bit_reg) : (sq_res_reg >> 1);
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg     <= 1'b1;
            drive_reg  <= 31'd65536;
            spring_reg <= 31'd65536;
            damp_reg   <= 31'd65536;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ENABLE:  en_reg     <= cfg_data[0];
                CFG_DRIVE:   drive_reg  <= cfg_data;
                CFG_SPRING:  spring_reg <= cfg_data;
                CFG_DAMPING: damp_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            dop_reg   <= D_VX;
            mop_reg   <= M_DXX;
            mph_reg   <= 1'b0;
            ppx_reg   <= '0;
            ppy_reg   <= '0;
            pvx_reg   <= '0;
            pvy_reg   <= '0;
            angle_reg <= '0;
            rate_reg  <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        px_reg   <= s_pivot_x;
                        py_reg   <= s_pivot_y;
                        dt_reg   <= s_time_step;
                        long_reg <= s_lever_long;
                        dx_reg   <= 33'(s_tip_x) - 33'(s_pivot_x);
                        dy_reg   <= 33'(s_tip_y) - 33'(s_pivot_y);
                        dop_reg  <= D_VX;
                        state_reg <= (s_time_step > 32'sd0) ? S_DSTART : S_OUT;
                    end
                end
                S_DSTART: begin
                    div_neg_reg <= num[63];
                    state_reg   <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_stat.done) begin
                        unique case (dop_reg)
                            D_VX: begin
                                vx_reg    <= div_val;
                                dop_reg   <= D_VY;
                                state_reg <= S_DSTART;
                            end
                            D_VY: begin
                                vy_reg    <= div_val;
                                dop_reg   <= D_AX;
                                state_reg <= S_DSTART;
                            end
                            D_AX: begin
                                ax_reg    <= div_val;
                                dop_reg   <= D_AY;
                                state_reg <= S_DSTART;
                            end
                            D_AY: begin
                                ay_reg  <= div_val;
                                ppx_reg <= px_reg;
                                ppy_reg <= py_reg;
                                pvx_reg <= vx_reg;
                                pvy_reg <= vy_reg;
                                if (!en_reg) begin
                                    angle_reg <= '0;
                                    rate_reg  <= '0;
                                    state_reg <= S_OUT;
                                end else if (!long_reg) begin
                                    state_reg <= S_OUT;
                                end else begin
                                    state_reg <= S_HALF;
                                end
                            end
                            default: begin
                                proj_reg  <= div_val;
                                mop_reg   <= M_DRV;
                                mph_reg   <= 1'b0;
                                state_reg <= S_MUL;
                            end
                        endcase
                    end
                end
                S_HALF: begin
                    if (big(dx_reg) || big(dy_reg)) begin
                        dx_reg <= half(dx_reg);
                        dy_reg <= half(dy_reg);
                    end else begin
                        mop_reg   <= M_DXX;
                        mph_reg   <= 1'b0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (!mph_reg) begin
                        prod_reg <= mul_p[63:0];
                        mph_reg  <= 1'b1;
                    end else begin
                        mph_reg <= 1'b0;
                        case (mop_reg)
                            M_DXX: begin
                                acc_reg <= prod_reg;
                                mop_reg <= M_DYY;
                            end
                            M_DYY: begin
                                sq_n_reg   <= 64'(acc_reg + prod_reg);
                                sq_res_reg <= '0;
                                sq_bit_reg <= SQ_TOP;
                                state_reg  <= S_SQRT;
                            end
                            M_AXDY: begin
                                acc_reg <= prod_reg;
                                mop_reg <= M_AYDX;
                            end
                            M_AYDX: begin
                                acc_reg <= acc_reg + prod_reg;
                                if (len_reg == 32'd0) begin
                                    proj_reg <= '0;
                                    mop_reg  <= M_DRV;
                                end else begin
                                    dop_reg   <= D_PRJ;
                                    state_reg <= S_DSTART;
                                end
                            end
                            M_DRV: begin
                                acc_reg <= -prod_tz;
                                mop_reg <= M_SPR;
                            end
                            M_SPR: begin
                                acc_reg <= acc_reg - prod_tz;
                                mop_reg <= M_DMP;
                            end
                            M_DMP: begin
                                f_reg   <= sat32(acc_reg - prod_tz);
                                mop_reg <= M_FDT;
                            end
                            M_FDT: begin
                                rate_reg <= sat32(64'(rate_reg) + prod_tz);
                                mop_reg  <= M_RDT;
                            end
                            default: begin
                                angle_reg <= sat32(64'(angle_reg) + prod_tz);
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_SQRT: begin
                    if (sq_fit) begin
                        sq_n_reg <= sq_n_reg - sq_try;
                    end
                    sq_res_reg <= sq_res_next;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg[0]) begin
                        len_reg   <= sq_res_next[31:0];
                        mop_reg   <= M_AXDY;
                        mph_reg   <= 1'b0;
                        state_reg <= S_MUL;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    `DSW_ASSERT_SAME(a_no_overlap, m_valid, !s_ready)
    `DSW_ASSERT_NEXT(a_skip_direct, accept && (s_time_step <= 32'sd0), m_valid)
    `DSW_ASSERT_SAME(a_div_idle_start, div_start, !div_stat.busy)
    `DSW_ASSERT_SAME(a_div_done_wait, div_stat.done, state_reg == S_DWAIT)

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import dsw_pkg::*;

    localparam int  FB         = FRAC_BITS_DEF;
    localparam int  STALL_LIM  = 20000;
    localparam int  SETTLE_CYC = 450;
    localparam longint Q1      = 64'sd1 <<< FB;
    localparam longint GRAV    = (Q1 + 50) / 100;
    localparam longint HI32    = 64'sd2147483647;
    localparam longint LO32    = -64'sd2147483648;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_pivot_x;
    logic signed [31:0] s_pivot_y;
    logic signed [31:0] s_tip_x;
    logic signed [31:0] s_tip_y;
    logic signed [31:0] s_time_step;
    logic               s_lever_long;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_angle;
    logic signed [31:0] m_angle_rate;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [30:0]        cfg_data;

    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] rate;
    } wobble_t;

    // predictor state and register copies
    logic   pm_enable;
    longint pm_drive, pm_spring, pm_damping;
    longint pm_px, pm_py, pm_vx, pm_vy, pm_angle, pm_rate;

    wobble_t wobble_q[$];
    int      n_mismatch;
    int      n_checked;
    int      n_sent;
    int      idle_pct;
    bit      hold_off;
    int      hold_len;
    int      quiet_cyc;

    damped_spring_wobble_step i_dut (.*);

    // clock
    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    function automatic longint clamp32(input longint v);
        if (v > HI32) return HI32;
        if (v < LO32) return LO32;
        return v;
    endfunction

    function automatic longint root64(input longint n);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    task automatic wobble_reset();
        pm_enable  = 1'b1;
        pm_drive   = 65536;
        pm_spring  = 65536;
        pm_damping = 65536;
        pm_px = 0; pm_py = 0; pm_vx = 0; pm_vy = 0;
        pm_angle = 0; pm_rate = 0;
    endtask

    // advance the predicted spring by one frame
    task automatic wobble_predict(input longint px, input longint py, input longint tx,
                                  input longint ty, input longint dt, input logic lng);
        longint vx, vy, ax, ay, dx, dy, len, proj, f;
        wobble_t w;
        if (dt > 0) begin
            vx = clamp32(((px - pm_px) * Q1) / dt);
            vy = clamp32(((py - pm_py) * Q1) / dt);
            ax = clamp32(((vx - pm_vx) * Q1) / dt);
            ay = clamp32(((vy - pm_vy + GRAV) * Q1) / dt);
            pm_px = px; pm_py = py; pm_vx = vx; pm_vy = vy;
            if (!pm_enable) begin
                pm_angle = 0;
                pm_rate  = 0;
            end else if (lng) begin
                dx = tx - px;
                dy = ty - py;
                while ((dx < 0 ? -dx : dx) >= (64'sd1 <<< 30) ||
                       (dy < 0 ? -dy : dy) >= (64'sd1 <<< 30)) begin
                    dx = dx / 2;
                    dy = dy / 2;
                end
                len  = root64(dx * dx + dy * dy);
                proj = (len != 0) ? clamp32((ax * -dy + ay * dx) / len) : 0;
                f = clamp32(-((pm_drive * proj) / Q1) - ((pm_spring * pm_angle) / Q1)
                            - ((pm_damping * pm_rate) / Q1));
                pm_rate  = clamp32(pm_rate + (f * dt) / Q1);
                pm_angle = clamp32(pm_angle + (pm_rate * dt) / Q1);
            end
        end
        w.angle = pm_angle[31:0];
        w.rate  = pm_rate[31:0];
        wobble_q.push_back(w);
    endtask

    // one request; valid held until accepted
    task automatic send_frame(input logic signed [31:0] px, input logic signed [31:0] py,
                              input logic signed [31:0] tx, input logic signed [31:0] ty,
                              input logic signed [31:0] dt, input logic lng);
        while ($urandom_range(99) < idle_pct) @(posedge aclk);
        s_valid      <= 1'b1;
        s_pivot_x    <= px;
        s_pivot_y    <= py;
        s_tip_x      <= tx;
        s_tip_y      <= ty;
        s_time_step  <= dt;
        s_lever_long <= lng;
        do @(posedge aclk); while (!s_ready);
        wobble_predict(px, py, tx, ty, dt, lng);
        n_sent++;
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (wobble_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // register write, only while idle
    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_ENABLE:  pm_enable  = val[0];
            CFG_DRIVE:   pm_drive   = val;
            CFG_SPRING:  pm_spring  = val;
            CFG_DAMPING: pm_damping = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    function automatic logic signed [31:0] rand_edge();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return '0;
            3: return $signed($urandom_range(1 << 20)) - (1 << 19);
            default: return $urandom;
        endcase
    endfunction

    // plausible motion: pivot within a moderate range, tip near the pivot; else edge values
    task automatic random_frame(input bit smooth);
        logic signed [31:0] px, py, dt;
        if (smooth) begin
            px = $signed($urandom_range(1 << 24)) - (1 << 23);
            py = $signed($urandom_range(1 << 24)) - (1 << 23);
            dt = ($urandom_range(9) == 0) ? -$signed($urandom_range(1 << 16))
                                          : $urandom_range(65536, 256);
            send_frame(px, py, px + $signed($urandom_range(1 << 22)) - (1 << 21),
                       py + $signed($urandom_range(1 << 22)) - (1 << 21),
                       dt, $urandom_range(7) != 0);
        end else begin
            send_frame(rand_edge(), rand_edge(), rand_edge(), rand_edge(), rand_edge(),
                       $urandom_range(1));
        end
    endtask

    task automatic test_directed();
        send_frame(0, 0, 0, 65536, 0, 1);
        send_frame(0, 0, 0, 65536, -65536, 1);
        send_frame(32'sh80000000, 0, 0, 0, 32'sh80000000, 1);
        send_frame(65536, 0, 65536, 65536, 1092, 1);
        send_frame(70000, 3000, 70000, 3000, 1092, 1);
        send_frame(70000, 3000, 70000, 3000, 1092, 0);
        send_frame(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 1, 1);
        send_frame(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1, 1);
        send_frame(0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1);
        send_frame(-5, 7, 1000, -1000, 65536, 1);
        send_frame(0, 0, 0, 0, 32'sh7fffffff, 0);
        drain();
        write_reg(CFG_ENABLE, 0);
        send_frame(100, 200, 300, 400, 65536, 1);
        send_frame(150, 250, 300, 0, 65536, 1);
        drain();
        write_reg(CFG_ENABLE, 1);
        write_reg(CFG_DRIVE, 31'h7fffffff);
        write_reg(CFG_SPRING, 31'h7fffffff);
        write_reg(CFG_DAMPING, 0);
        send_frame(0, 0, 65536, 0, 65536, 1);
        send_frame(1 << 20, -(1 << 20), 0, 0, 600, 1);
        send_frame(0, 0, 65536, 0, 65536, 1);
        drain();
    endtask

    task automatic test_random_configs(input int n_phase, input int per_phase);
        for (int ph = 0; ph < n_phase; ph++) begin
            write_reg(CFG_ENABLE, ($urandom_range(4) != 0));
            write_reg(CFG_DRIVE, (ph % 4 == 0) ? 31'h0 : $urandom_range(1 << 19));
            write_reg(CFG_SPRING, (ph % 5 == 1) ? 31'h7fffffff : $urandom_range(1 << 19));
            write_reg(CFG_DAMPING, (ph % 6 == 2) ? 31'h7fffffff : $urandom_range(1 << 19));
            write_reg(CFG_ENABLE + 0, $urandom); // reach both values of upper data bits
            write_reg(CFG_ENABLE, 1);
            idle_pct = (ph % 3 == 0) ? 0 : 8;
            for (int k = 0; k < per_phase; k++) random_frame($urandom_range(9) != 0);
            drain();
        end
    endtask

    // receiver holds off while the sender keeps offering requests
    task automatic test_back_pressure();
        hold_len = 3000;
        hold_off = 1'b1;
        for (int k = 0; k < 10; k++) random_frame(1);
        drain();
    endtask

    // result checker and receiver idling
    always @(posedge aclk) begin
        wobble_t w;
        if (aresetn && m_valid && m_ready) begin
            n_checked++;
            if (wobble_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result %0d", m_angle);
            end else begin
                w = wobble_q.pop_front();
                if (w.angle !== m_angle || w.rate !== m_angle_rate) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch angle exp %0d got %0d, rate exp %0d got %0d",
                                 w.angle, m_angle, w.rate, m_angle_rate);
                end
            end
        end
        if (hold_off) begin
            m_ready <= 1'b0;
            if (hold_len == 0) hold_off <= 1'b0;
            else hold_len <= hold_len - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // watchdog on cycles with no accepted request or taken result, outside hold-off
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || hold_off) quiet_cyc <= 0;
        else quiet_cyc <= quiet_cyc + 1;
        if (quiet_cyc > STALL_LIM) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0; s_valid = 1'b0; m_ready = 1'b0; cfg_we = 1'b0;
        cfg_index = '0; cfg_data = '0; s_pivot_x = '0; s_pivot_y = '0;
        s_tip_x = '0; s_tip_y = '0; s_time_step = '0; s_lever_long = 1'b0;
        n_mismatch = 0; n_checked = 0; n_sent = 0; idle_pct = 8;
        hold_off = 1'b0; hold_len = 0; quiet_cyc = 0;
        wobble_reset();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_back_pressure();
        test_random_configs(20, 100);
        $display("covered %0d frames with %0d results over 20 gain settings,", n_sent, n_checked);
        $display("including extreme coordinates, skipped steps and physics off");
        if (n_mismatch == 0 && wobble_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
